@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the asynchronous active-low reset is asserted.
`define SKT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define SKT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/skt_pkg.sv @@
`timescale 1ns / 1ps
package skt_pkg;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned ADDR_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned ENTRY_W      = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_REBUILD = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // Datapath micro-operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_UP_RD,
    OP_UP_WR,
    OP_DN_RD,
    OP_DN_WR,
    OP_RD_RD,
    OP_SO_RD,
    OP_SO_GET,
    OP_SO_RDP,
    OP_SO_CMP,
    OP_SO_PUT,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       err;
    logic       len_zero;
    logic       a_gt_first;
    logic       a_more;
    logic       i_more;
    logic       a_zero;
    logic       lt;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/skt_if.sv @@
`timescale 1ns / 1ps
interface skt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] key;
  logic [31:0] payload;
  logic [7:0]  index;

  modport source (output valid, command, key, payload, index, input ready);
  modport sink (input valid, command, key, payload, index, output ready);
endinterface

interface skt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  position;
  logic        moved;
  logic [31:0] read_key;
  logic [31:0] read_payload;
  logic [8:0]  entry_count;
  logic        is_sorted;

  modport source (output valid, status, position, moved, read_key, read_payload,
                  entry_count, is_sorted, input ready);
  modport sink (input valid, status, position, moved, read_key, read_payload,
                entry_count, is_sorted, output ready);
endinterface

@@ rtl/core/skt_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module skt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skt_pkg::dp_op_e      op_i,
  input  logic [2:0]           command_i,
  input  logic [31:0]          key_i,
  input  logic [31:0]          payload_i,
  input  logic [7:0]           index_i,
  output skt_pkg::dp_stat_t    stat_o,
  skt_rsp_if.source            rsp_o
);
  import skt_pkg::*;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               we;
  logic [ADDR_W-1:0]  wa;
  logic [ENTRY_W-1:0] wd;

  logic [2:0]              cmd_q;
  logic [KEY_BITS-1:0]     hk_q, hk_d;
  logic [PAYLOAD_BITS-1:0] hp_q, hp_d;
  logic [7:0]              idx_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    sorted_q, sorted_d;
  logic [CNT_W-1:0]        first_q, first_d, len_q, len_d, a_q, a_d, b_q, b_d;
  logic                    chg_q, chg_d;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        idx_ext;
  logic [KEY_BITS-1:0]     rd_key;
  logic                    lt, full, bad;

  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic [7:0]  opos_q, opos_d;
  logic        omov_q, omov_d;
  logic [31:0] okey_q, okey_d, opay_q, opay_d;

  assign mid     = first_q + (len_q >> 1);
  assign idx_ext = {1'b0, idx_q};
  assign rd_key  = rd_q[ENTRY_W-1:PAYLOAD_BITS];
  assign lt      = hk_q < rd_key;
  assign full    = cnt_q == CNT_W'(CAPACITY);
  assign bad     = idx_ext >= cnt_q;

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.err        = ((cmd_q == CMD_INSERT) || (cmd_q == CMD_APPEND)) ? full :
                        ((cmd_q == CMD_DELETE) || (cmd_q == CMD_READ)) ? bad : 1'b0;
    stat_o.len_zero   = len_q == '0;
    stat_o.a_gt_first = a_q > first_q;
    stat_o.a_more     = (a_q + CNT_W'(1)) < cnt_q;
    stat_o.i_more     = b_q < cnt_q;
    stat_o.a_zero     = a_q == '0;
    stat_o.lt         = lt;
    stat_o.out_free   = !ov_q || rsp_o.ready;
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (op_i)
      OP_SRCH_RD: rd_addr = mid[ADDR_W-1:0];
      OP_UP_RD:   rd_addr = a_q[ADDR_W-1:0] - ADDR_W'(1);
      OP_DN_RD:   rd_addr = a_q[ADDR_W-1:0] + ADDR_W'(1);
      OP_RD_RD:   rd_addr = idx_q[ADDR_W-1:0];
      OP_SO_RD:   rd_addr = b_q[ADDR_W-1:0];
      OP_SO_RDP:  rd_addr = a_q[ADDR_W-1:0] - ADDR_W'(1);
      default:    rd_en = 1'b0;
    endcase
  end

  always_comb begin
    hk_d = hk_q; hp_d = hp_q; cnt_d = cnt_q; sorted_d = sorted_q;
    first_d = first_q; len_d = len_q; a_d = a_q; b_d = b_q; chg_d = chg_q;
    we = 1'b0; wa = a_q[ADDR_W-1:0]; wd = rd_q;
    ov_d = ov_q && !rsp_o.ready;
    ost_d = ost_q; opos_d = opos_q; omov_d = omov_q; okey_d = okey_q; opay_d = opay_q;
    unique case (op_i)
      OP_LOAD: begin
        hk_d  = key_i[KEY_BITS-1:0];
        hp_d  = payload_i[PAYLOAD_BITS-1:0];
        chg_d = 1'b0;
        b_d   = CNT_W'(1);
        if (command_i == CMD_INSERT) begin
          first_d = '0;
          len_d   = cnt_q;
        end else begin
          first_d = cnt_q;
          len_d   = '0;
        end
        if ((command_i == CMD_INSERT) || (command_i == CMD_APPEND)) begin
          a_d = cnt_q;
        end else begin
          a_d = {1'b0, index_i};
        end
      end
      OP_SRCH_CMP: begin
        if (lt) begin
          len_d = len_q >> 1;
        end else begin
          first_d = mid + CNT_W'(1);
          len_d   = len_q - (len_q >> 1) - CNT_W'(1);
        end
      end
      OP_UP_WR: begin
        we  = 1'b1;
        a_d = a_q - CNT_W'(1);
      end
      OP_DN_WR: begin
        we  = 1'b1;
        a_d = a_q + CNT_W'(1);
      end
      OP_SO_GET: begin
        hk_d = rd_key;
        hp_d = rd_q[PAYLOAD_BITS-1:0];
        a_d  = b_q;
      end
      OP_SO_CMP: begin
        if (lt) begin
          we  = 1'b1;
          a_d = a_q - CNT_W'(1);
        end
      end
      OP_SO_PUT: begin
        if (a_q != b_q) begin
          we    = 1'b1;
          wd    = {hk_q, hp_q};
          chg_d = 1'b1;
        end
        b_d = b_q + CNT_W'(1);
      end
      OP_FIN: begin
        ov_d = 1'b1; ost_d = ST_OK; opos_d = '0; omov_d = 1'b0;
        okey_d = '0; opay_d = '0;
        unique case (cmd_q)
          CMD_INSERT, CMD_APPEND: begin
            if (full) begin
              ost_d = ST_FULL;
            end else begin
              we     = 1'b1;
              wa     = first_q[ADDR_W-1:0];
              wd     = {hk_q, hp_q};
              cnt_d  = cnt_q + CNT_W'(1);
              opos_d = first_q[7:0];
              omov_d = first_q != cnt_q;
              if (cmd_q == CMD_APPEND) sorted_d = 1'b0;
            end
          end
          CMD_DELETE: begin
            if (bad) begin
              ost_d = ST_BAD_INDEX;
            end else begin
              cnt_d  = cnt_q - CNT_W'(1);
              opos_d = idx_q;
              omov_d = (idx_ext + CNT_W'(1)) != cnt_q;
            end
          end
          CMD_READ: begin
            if (bad) begin
              ost_d = ST_BAD_INDEX;
            end else begin
              opos_d = idx_q;
              okey_d = rd_key;
              opay_d = rd_q[PAYLOAD_BITS-1:0];
            end
          end
          CMD_REBUILD: begin
            sorted_d = 1'b1;
            omov_d   = chg_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      cmd_q <= command_i;
      idx_q <= index_i;
    end
    hk_q <= hk_d; hp_q <= hp_d;
    first_q <= first_d; len_q <= len_d; a_q <= a_d; b_q <= b_d; chg_q <= chg_d;
    ost_q <= ost_d; opos_q <= opos_d; omov_q <= omov_d; okey_q <= okey_d; opay_q <= opay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sorted_q <= 1'b1;
      ov_q     <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      sorted_q <= sorted_d;
      ov_q     <= ov_d;
    end
  end

  logic [8:0] ocnt_q;
  logic       osrt_q;
  always_ff @(posedge clk_i) begin
    if (op_i == OP_FIN) begin
      ocnt_q <= 9'(cnt_d);
      osrt_q <= sorted_d;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.position     = opos_q;
  assign rsp_o.moved        = omov_q;
  assign rsp_o.read_key     = okey_q;
  assign rsp_o.read_payload = opay_q;
  assign rsp_o.entry_count  = ocnt_q;
  assign rsp_o.is_sorted    = osrt_q;

  `SKT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `SKT_ASSERT_NEXT(a_cnt_only_fin, clk_i, rst_ni, op_i != OP_FIN, $stable(cnt_q),
                   "count changed outside finish")
  `SKT_ASSERT(a_valid_from_fin, clk_i, rst_ni, $rose(ov_q) |-> $past(op_i == OP_FIN),
              "result raised without finish")
endmodule

@@ rtl/core/skt_ctrl.sv @@
`timescale 1ns / 1ps
module skt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  skt_pkg::dp_stat_t stat_i,
  output skt_pkg::dp_op_e   op_o
);
  import skt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISP     = 15'b000000000000010,
    S_SRCH     = 15'b000000000000100,
    S_SRCH_CMP = 15'b000000000001000,
    S_UP       = 15'b000000000010000,
    S_UP_WR    = 15'b000000000100000,
    S_DN       = 15'b000000001000000,
    S_DN_WR    = 15'b000000010000000,
    S_RD       = 15'b000000100000000,
    S_SO_OUT   = 15'b000001000000000,
    S_SO_GET   = 15'b000010000000000,
    S_SO_IN    = 15'b000100000000000,
    S_SO_CMP   = 15'b001000000000000,
    S_SO_PUT   = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.err) begin
          state_d = S_FIN;
        end else begin
          unique case (stat_i.cmd)
            CMD_INSERT, CMD_APPEND: state_d = S_SRCH;
            CMD_DELETE:             state_d = S_DN;
            CMD_READ:               state_d = S_RD;
            CMD_REBUILD:            state_d = S_SO_OUT;
            default:                state_d = S_FIN;
          endcase
        end
      end
      S_SRCH: begin
        if (stat_i.len_zero) begin
          state_d = S_UP;
        end else begin
          op_o    = OP_SRCH_RD;
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        op_o    = OP_SRCH_CMP;
        state_d = S_SRCH;
      end
      S_UP: begin
        if (stat_i.a_gt_first) begin
          op_o    = OP_UP_RD;
          state_d = S_UP_WR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UP_WR: begin
        op_o    = OP_UP_WR;
        state_d = S_UP;
      end
      S_DN: begin
        if (stat_i.a_more) begin
          op_o    = OP_DN_RD;
          state_d = S_DN_WR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_WR: begin
        op_o    = OP_DN_WR;
        state_d = S_DN;
      end
      S_RD: begin
        op_o    = OP_RD_RD;
        state_d = S_FIN;
      end
      S_SO_OUT: begin
        if (stat_i.i_more) begin
          op_o    = OP_SO_RD;
          state_d = S_SO_GET;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SO_GET: begin
        op_o    = OP_SO_GET;
        state_d = S_SO_IN;
      end
      S_SO_IN: begin
        if (stat_i.a_zero) begin
          state_d = S_SO_PUT;
        end else begin
          op_o    = OP_SO_RDP;
          state_d = S_SO_CMP;
        end
      end
      S_SO_CMP: begin
        op_o    = OP_SO_CMP;
        state_d = stat_i.lt ? S_SO_IN : S_SO_PUT;
      end
      S_SO_PUT: begin
        op_o    = OP_SO_PUT;
        state_d = S_SO_OUT;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          op_o    = OP_FIN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ rtl/core/sorted_key_table.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake    Payload
// req_i     in   valid/ready  command, key, payload, index
// rsp_o     out  valid/ready  status, position, moved, read_key, read_payload,
//                             entry_count, is_sorted
//
// One command is worked at a time; a new transaction is taken while the previous
// result still waits in the output register.
// Insert and append search with at most log2(count) + 1 probes and then shift
// entries up; delete shifts entries down; read fetches one entry. The entry
// memory is read and written once per entry moved, in separate steps. Rebuild
// is an insertion sort whose work grows with the entries passed over, up to
// quadratic. A rejected command goes straight to the finishing step.
// Reset clears the count and sets the sorted flag; the entry memory is not cleared.
// A stalled result holds the finishing step, so the block stops until it is taken.
module sorted_key_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  skt_req_if.sink    req_i,
  skt_rsp_if.source  rsp_o
);
  import skt_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;
  logic     ready;

  assign req_i.ready = ready;

  // The controller sequences micro-operations; the datapath owns the memory,
  // the count, the sorted flag and the result register.
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  skt_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .command_i (req_i.command),
    .key_i     (req_i.key),
    .payload_i (req_i.payload),
    .index_i   (req_i.index),
    .stat_o    (stat),
    .rsp_o     (rsp_o)
  );
endmodule

@@ verif/tb_channels.sv @@
`timescale 1ns / 1ps
// Testbench-side result type for the response channel.
package tb_table_pkg;
  import skt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  position;
    logic        moved;
    logic [31:0] read_key;
    logic [31:0] read_payload;
    logic [8:0]  entry_count;
    logic        is_sorted;
  } table_result_t;
endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import skt_pkg::*;
  import tb_table_pkg::*;

  logic clk_i;
  logic rst_ni;

  skt_req_if req_if ();
  skt_rsp_if rsp_if ();

  sorted_key_table i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the table, kept by the predictor.
  logic [31:0] shadow_keys [CAPACITY];
  logic [31:0] shadow_pays [CAPACITY];
  int unsigned shadow_count;
  logic        shadow_sorted;

  table_result_t expected_results[$];
  int unsigned   mismatch_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The run must end well before this even on the slowest legal path.
  initial begin
    #40ms;
    $display("FAIL sorted_key_table");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Computes the result of one command and updates the shadow table.
  function automatic table_result_t predict_table_command(input logic [2:0] cmd,
      input logic [31:0] key, input logic [31:0] pay, input logic [7:0] idx);
    table_result_t r;
    int unsigned first, len, half, pos, j;
    logic [31:0] k, p;
    r = '0;
    case (cmd)
      CMD_INSERT, CMD_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_INSERT) begin
            // Upper-bound binary search, run even when the table is unsorted.
            first = 0;
            len = shadow_count;
            while (len > 0) begin
              half = len / 2;
              if (key < shadow_keys[first + half]) begin
                len = half;
              end else begin
                first = first + half + 1;
                len = len - half - 1;
              end
            end
            pos = first;
          end else begin
            pos = shadow_count;
            shadow_sorted = 1'b0;
          end
          if (pos != shadow_count) r.moved = 1'b1;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_pays[i] = shadow_pays[i - 1];
          end
          shadow_keys[pos] = key;
          shadow_pays[pos] = pay;
          shadow_count++;
          r.position = pos[7:0];
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (idx >= shadow_count) begin
          r.status = ST_BAD_INDEX;
        end else if (cmd == CMD_DELETE) begin
          if (idx + 1 < shadow_count) r.moved = 1'b1;
          for (int i = idx; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_pays[i] = shadow_pays[i + 1];
          end
          shadow_count--;
          r.position = idx;
        end else begin
          r.read_key = shadow_keys[idx];
          r.read_payload = shadow_pays[idx];
          r.position = idx;
        end
      end
      CMD_REBUILD: begin
        // Stable insertion sort; equal keys never pass each other.
        for (int i = 1; i < shadow_count; i++) begin
          k = shadow_keys[i];
          p = shadow_pays[i];
          j = i;
          while (j > 0 && k < shadow_keys[j - 1]) begin
            shadow_keys[j] = shadow_keys[j - 1];
            shadow_pays[j] = shadow_pays[j - 1];
            j--;
          end
          if (j != i) begin
            shadow_keys[j] = k;
            shadow_pays[j] = p;
            r.moved = 1'b1;
          end
        end
        shadow_sorted = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = shadow_count[8:0];
    r.is_sorted = shadow_sorted;
    return r;
  endfunction

  // Sends one transaction, with random idle cycles ahead of it.
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] key,
                              input logic [31:0] pay, input logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.key <= key;
    req_if.payload <= pay;
    req_if.index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_results = {expected_results, predict_table_command(cmd, key, pay, idx)};
    req_if.valid <= 1'b0;
    // The block is busy for the next cycle anyway, so no accept is lost here.
    @(posedge clk_i);
  endtask

  // Receiver: random stalls and the field-by-field check of each result.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.position !== want.position)
            report_mismatch("position", 32'(rsp_if.position), 32'(want.position));
          if (rsp_if.moved !== want.moved)
            report_mismatch("moved", 32'(rsp_if.moved), 32'(want.moved));
          if (rsp_if.read_key !== want.read_key)
            report_mismatch("read_key", rsp_if.read_key, want.read_key);
          if (rsp_if.read_payload !== want.read_payload)
            report_mismatch("read_payload", rsp_if.read_payload, want.read_payload);
          if (rsp_if.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(rsp_if.entry_count),
                            32'(want.entry_count));
          if (rsp_if.is_sorted !== want.is_sorted)
            report_mismatch("is_sorted", 32'(rsp_if.is_sorted), 32'(want.is_sorted));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Keys drawn from a small set often, so that equal keys are common.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFF8 | $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_corners();
    send_command(CMD_READ, 0, 0, 8'd0);
    send_command(CMD_DELETE, 0, 0, 8'd255);
    send_command(CMD_REBUILD, 0, 0, 0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_INSERT, 32'd0, 32'd0, 0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 0);
    send_command(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 0);
    send_command(CMD_APPEND, 32'd0, 32'h5A5A_5A5A, 0);
    send_command(CMD_INSERT, 32'h4000_0000, 32'd1, 0);
    send_command(CMD_READ, 0, 0, 8'd5);
    send_command(CMD_READ, 0, 0, 8'd6);
    send_command(CMD_REBUILD, 0, 0, 0);
    send_command(CMD_REBUILD, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_command(CMD_READ, 0, 0, i[7:0]);
    send_command(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(3'd6, 0, 0, 0);
    send_command(3'd7, 0, 0, 0);
    send_command(CMD_DELETE, 0, 0, 8'd5);
    send_command(CMD_DELETE, 0, 0, 8'd0);
    send_command(CMD_DELETE, 0, 0, 8'd4);
  endtask

  // Fills the table to capacity, then hits it when full, then drains it.
  task automatic test_full_table();
    while (shadow_count < CAPACITY)
      send_command($urandom_range(1) ? CMD_INSERT : CMD_APPEND, pick_key(),
                   $urandom, 0);
    send_command(CMD_INSERT, $urandom, $urandom, 0);
    send_command(CMD_APPEND, $urandom, $urandom, 0);
    send_command(CMD_READ, 0, 0, 8'd255);
    send_command(CMD_REBUILD, 0, 0, 0);
    send_command(CMD_DELETE, 0, 0, 8'd255);
    while (shadow_count > 0)
      send_command(CMD_DELETE, 0, 0, 8'($urandom_range(shadow_count - 1)));
  endtask

  // Random mix on small tables; reads are steered below the count more often, and
  // an out-of-range read touches no entry; other commands see any index.
  task automatic test_random_mix(input int unsigned items);
    logic [2:0] cmd;
    logic [7:0] idx;
    for (int n = 0; n < items; n++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: cmd = (shadow_count > 40) ? CMD_DELETE : CMD_INSERT;
        6, 7, 8: cmd = CMD_APPEND;
        9, 10, 11, 12: cmd = CMD_DELETE;
        13, 14, 15, 16: cmd = CMD_READ;
        17, 18: cmd = CMD_REBUILD;
        default: cmd = 3'($urandom_range(7));
      endcase
      if (shadow_count > 0 && $urandom_range(3) != 0)
        idx = 8'($urandom_range(shadow_count - 1));
      else
        idx = 8'($urandom);
      if (cmd == CMD_READ && idx >= shadow_count && shadow_count > 0 &&
          $urandom_range(1))
        idx = 8'(shadow_count - 1);
      send_command(cmd, pick_key(), $urandom, idx);
    end
  endtask

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    mismatch_count = 0;
    shadow_count = 0;
    shadow_sorted = 1'b1;
    send_idle_pct = 33;
    recv_stall_pct = 48;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_READ;
    req_if.key = '0;
    req_if.payload = '0;
    req_if.index = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_mix(500);
    test_full_table();
    send_idle_pct = 48;
    recv_stall_pct = 33;
    test_random_mix(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(450);

    wait_for_drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/skt_pkg.sv
rtl/core/skt_if.sv
rtl/core/skt_datapath.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table.sv
verif/tb_channels.sv
verif/tb_top.sv
